@@ design/sasf_pkg.sv @@
// ----------------------------------------------------------------------------
// sasf_pkg
// Shared types and constants of the sonar average and spike filter.
// ----------------------------------------------------------------------------
package sasf_pkg;

    localparam int WINDOW_DEF     = 10;
    localparam int STEPS_DEF      = 2048;

    localparam int ECHO_W         = 20;
    localparam int POS_W          = 16;
    localparam int SCALE_W        = 16;
    localparam int DIST_W         = 25;
    localparam int THR_W          = 25;
    localparam int ANGLE_W        = 9;
    localparam int DEG_W          = 9;
    localparam int DEG_PER_TURN   = 360;
    localparam int SCALE_SHIFT    = 8;

    localparam int PADDR_W        = 3;
    localparam int PDATA_W        = 32;
    localparam int REG_IDX_W      = 1;

    localparam logic [REG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
    localparam logic [REG_IDX_W-1:0] REG_SCALE     = 1'b1;

    localparam logic [THR_W-1:0]   THR_RST   = 25'd5120;
    localparam logic [SCALE_W-1:0] SCALE_RST = 16'd4915;

    localparam logic [DIST_W-1:0]  DIST_MAX  = {DIST_W{1'b1}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_RING,
        S_FILT_WAIT,
        S_ANG,
        S_ANG_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [ECHO_W-1:0]        echo_us;
        logic signed [POS_W-1:0]  step_position;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_W-1:0] angle_deg;
        logic [DIST_W-1:0]  report_q8;
        logic               spike;
        logic [DIST_W-1:0]  raw_q8;
        logic [DIST_W-1:0]  average_q8;
    } t_out_item;

    typedef struct packed {
        logic cap_in;
        logic ring_upd;
        logic ang_start;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic avg_busy;
        logic mod_busy;
        logic ang_busy;
    } t_dp_sts;

endpackage

@@ design/sasf_regs.sv @@
// ----------------------------------------------------------------------------
// sasf_regs
// Configuration registers behind a simple APB-style port.
// ----------------------------------------------------------------------------
module sasf_regs
    import sasf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready,
    output logic [THR_W-1:0]     o_threshold,
    output logic [SCALE_W-1:0]   o_scale
);

    logic [THR_W-1:0]     r_threshold;
    logic [SCALE_W-1:0]   r_scale;
    logic [REG_IDX_W-1:0] reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THR_RST;
            r_scale     <= SCALE_RST;
        end else if (psel && penable && pwrite && pready) begin
            case (reg_idx)
                REG_THRESHOLD: r_threshold <= pwdata[THR_W-1:0];
                REG_SCALE:     r_scale     <= pwdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_THRESHOLD: prdata = PDATA_W'(r_threshold);
            REG_SCALE:     prdata = PDATA_W'(r_scale);
            default:       prdata = '0;
        endcase
    end

    assign o_threshold = r_threshold;
    assign o_scale     = r_scale;

endmodule

@@ design/sasf_div.sv @@
// ----------------------------------------------------------------------------
// sasf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sasf_div
    import sasf_pkg::*;
#(
    parameter int DW = 16,
    parameter int VW = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [VW-1:0] i_divisor,
    output logic [DW-1:0] o_quo,
    output logic          o_busy
);

    localparam int NW = $clog2(DW + 1);

    logic [NW-1:0] r_cnt;
    logic          r_busy;
    logic [DW-1:0] r_quo;
    logic [VW-1:0] r_rem;
    logic [VW-1:0] r_div;
    logic [VW:0]   shifted;
    logic [VW:0]   trial;
    logic          fits;

    assign shifted = {r_rem, r_quo[DW-1]};
    assign fits    = (shifted >= {1'b0, r_div});
    assign trial   = shifted - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= NW'(DW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == NW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DW-2:0], fits};
            r_rem <= fits ? trial[VW-1:0] : shifted[VW-1:0];
        end
    end

    assign o_quo  = r_quo;
    assign o_busy = r_busy;

endmodule

@@ design/sasf_ctrl.sv @@
// ----------------------------------------------------------------------------
// sasf_ctrl
// Sequencer for one item: scale, ring update, divisions, result load.
// ----------------------------------------------------------------------------
module sasf_ctrl
    import sasf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_stall,
    output logic    o_out_valid,
    input  logic    i_out_stall,
    output t_dp_cmd o_cmd,
    input  t_dp_sts i_sts
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:      if (i_in_valid) n_state = S_MUL;
            S_MUL:       n_state = S_RING;
            S_RING:      n_state = S_FILT_WAIT;
            S_FILT_WAIT: if (!i_sts.avg_busy && !i_sts.mod_busy) n_state = S_ANG;
            S_ANG:       n_state = S_ANG_WAIT;
            S_ANG_WAIT:  if (!i_sts.ang_busy) n_state = S_OUT;
            S_OUT:       if (out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.cap_in    = (r_state == S_IDLE) && i_in_valid;
        o_cmd.ring_upd  = (r_state == S_RING);
        o_cmd.ang_start = (r_state == S_ANG);
        o_cmd.out_load  = (r_state == S_OUT) && out_free;
        o_in_stall      = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

@@ design/sasf_dp.sv @@
// ----------------------------------------------------------------------------
// sasf_dp
// Datapath: echo scaling, sample ring with running sum, average divider,
// angle by reciprocal multiplication, spike decision and result register.
// ----------------------------------------------------------------------------
module sasf_dp
    import sasf_pkg::*;
#(
    parameter int WINDOW         = WINDOW_DEF,
    parameter int STEPS_PER_TURN = STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_sts            o_sts,
    input  t_in_item           i_in_data,
    input  logic [THR_W-1:0]   i_threshold,
    input  logic [SCALE_W-1:0] i_scale,
    output t_out_item          o_out_data
);

    localparam int SW     = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CW     = $clog2(WINDOW + 1);
    localparam int SUM_W  = DIST_W + CW;
    localparam int SVW    = $clog2(STEPS_PER_TURN + 1);
    localparam int AW     = $clog2(STEPS_PER_TURN);
    localparam int ADW    = AW + DEG_W;
    localparam int PROD_W = ECHO_W + SCALE_W;
    localparam int MPW    = 2 * POS_W;
    localparam int RW     = POS_W + 1;
    localparam int APW    = 2 * ADW;
    localparam int AEW    = ADW + 1;

    localparam logic [SW-1:0]    LAST_SLOT = SW'(WINDOW - 1);
    localparam logic [CW-1:0]    WIN_CNT   = CW'(WINDOW);
    localparam logic [SVW-1:0]   STEPS_V   = SVW'(STEPS_PER_TURN);
    localparam logic [ADW-1:0]   DEG_V     = ADW'(DEG_PER_TURN);
    localparam logic [POS_W-1:0] MOD_M     = POS_W'((64'd1 << POS_W) / STEPS_PER_TURN);
    localparam logic [ADW-1:0]   ANG_M     = ADW'((64'd1 << ADW) / STEPS_PER_TURN);
    localparam logic [RW-1:0]    STEPS_R   = RW'(STEPS_PER_TURN);
    localparam logic [AEW-1:0]   STEPS_A   = AEW'(STEPS_PER_TURN);

    logic [ECHO_W-1:0] r_echo;
    logic [POS_W-1:0]  r_pos;
    logic [PROD_W-1:0] r_prod;
    logic [DIST_W-1:0] r_raw;
    logic [DIST_W-1:0] r_ring [WINDOW];
    logic [SW-1:0]     r_slot;
    logic              r_full;
    logic [SUM_W-1:0]  r_sum;
    t_out_item         r_out;
    logic [POS_W-1:0]  r_mod_q;
    logic [SVW-1:0]    r_mod_rem;
    logic              r_mod_busy;
    logic [ADW-1:0]    r_ang_q;
    logic [ADW-1:0]    r_ang_quo;
    logic              r_ang_busy;

    logic [PROD_W-SCALE_SHIFT-1:0] dist_q8;
    logic [DIST_W-1:0]  raw_sat;
    logic [SUM_W-1:0]   n_sum;
    logic               slot_wrap;
    logic [SW-1:0]      n_slot;
    logic [CW-1:0]      count;
    logic [POS_W-1:0]   pos_mag;
    logic [MPW-1:0]     mod_prod;
    logic [RW-1:0]      mod_est;
    logic [SVW-1:0]     pos_mod;
    logic [ADW-1:0]     ang_dividend;
    logic [APW-1:0]     ang_prod;
    logic [AEW-1:0]     ang_est;
    logic [SUM_W-1:0]   avg_quo;
    logic [DIST_W-1:0]  avg_sat;
    logic [DIST_W-1:0]  diff;
    logic               spike;

    // scaling
    always_ff @(posedge i_clk) begin
        if (i_cmd.cap_in) begin
            r_echo <= i_in_data.echo_us;
            r_pos  <= i_in_data.step_position;
        end
        r_prod <= PROD_W'(r_echo) * PROD_W'(i_scale);
    end

    assign dist_q8 = r_prod[PROD_W-1:SCALE_SHIFT];
    assign raw_sat = (|dist_q8[PROD_W-SCALE_SHIFT-1:DIST_W]) ? DIST_MAX : dist_q8[DIST_W-1:0];

    // ring and running sum
    assign n_sum     = r_sum - SUM_W'(r_ring[r_slot]) + SUM_W'(raw_sat);
    assign slot_wrap = (r_slot == LAST_SLOT);
    assign n_slot    = slot_wrap ? '0 : r_slot + 1'b1;
    assign count     = (slot_wrap || r_full) ? WIN_CNT : CW'(r_slot) + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_ring[i] <= '0;
            end
            r_slot <= '0;
            r_full <= 1'b0;
            r_sum  <= '0;
        end else if (i_cmd.ring_upd) begin
            r_ring[r_slot] <= raw_sat;
            r_slot         <= n_slot;
            r_sum          <= n_sum;
            if (slot_wrap) begin
                r_full <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_upd) begin
            r_raw <= raw_sat;
        end
    end

    // average divider
    sasf_div #(
        .DW (SUM_W),
        .VW (CW)
    ) u_avg_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.ring_upd),
        .i_dividend (n_sum),
        .i_divisor  (count),
        .o_quo      (avg_quo),
        .o_busy     (o_sts.avg_busy)
    );

    // position modulo and angle, reciprocal estimate plus one correction step
    assign pos_mag  = r_pos[POS_W-1] ? (~r_pos + 1'b1) : r_pos;
    assign mod_prod = MPW'(pos_mag) * MPW'(MOD_M);
    assign mod_est  = RW'(pos_mag) - RW'(r_mod_q) * STEPS_R;
    assign pos_mod  = (r_pos[POS_W-1] && (r_mod_rem != '0)) ? (STEPS_V - r_mod_rem) : r_mod_rem;
    assign ang_dividend = ADW'(pos_mod[AW-1:0]) * DEG_V;
    assign ang_prod = APW'(ang_dividend) * APW'(ANG_M);
    assign ang_est  = AEW'(ang_dividend) - AEW'(r_ang_q) * STEPS_A;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mod_busy <= 1'b0;
            r_ang_busy <= 1'b0;
        end else begin
            r_mod_busy <= i_cmd.ring_upd;
            r_ang_busy <= i_cmd.ang_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ring_upd) begin
            r_mod_q <= mod_prod[MPW-1:POS_W];
        end
        if (r_mod_busy) begin
            r_mod_rem <= (mod_est >= STEPS_R) ? SVW'(mod_est - STEPS_R) : SVW'(mod_est);
        end
        if (i_cmd.ang_start) begin
            r_ang_q <= ang_prod[APW-1:ADW];
        end
        if (r_ang_busy) begin
            r_ang_quo <= (ang_est >= STEPS_A) ? (r_ang_q + 1'b1) : r_ang_q;
        end
    end

    assign o_sts.mod_busy = r_mod_busy;
    assign o_sts.ang_busy = r_ang_busy;

    // spike decision
    assign avg_sat = (|avg_quo[SUM_W-1:DIST_W]) ? DIST_MAX : avg_quo[DIST_W-1:0];
    assign diff    = (r_raw > avg_sat) ? (r_raw - avg_sat) : (avg_sat - r_raw);
    assign spike   = (diff > i_threshold);

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.angle_deg  <= r_ang_quo[ANGLE_W-1:0];
            r_out.report_q8  <= spike ? r_raw : avg_sat;
            r_out.spike      <= spike;
            r_out.raw_q8     <= r_raw;
            r_out.average_q8 <= avg_sat;
        end
    end

    assign o_out_data = r_out;

endmodule

@@ design/sonar_average_spike_filter_unit.sv @@
// ----------------------------------------------------------------------------
// sonar_average_spike_filter_unit
// Sonar echo to distance, moving average over a sample ring with spike
// bypass, and stepper position to scan angle.
// ----------------------------------------------------------------------------
//  port group   direction  handshake             beat
//  input        in         i_in_valid/o_in_stall  t_in_item  (echo, position)
//  output       out        o_out_valid/i_out_stall t_out_item (angle, distances)
//  config       in/out     psel/penable/pready    32-bit register access
//
//  one item passes states MUL, RING, FILT_WAIT, ANG, ANG_WAIT and OUT from one accepted
//  beat to the next; FILT_WAIT waits for the bit-serial average divider
//  the angle takes a reciprocal multiply step and a correction step after the average is done
//  reset clears the ring, the running sum and the control state at once
//  a finished beat waits in the output register while the next item is taken
//  the input stalls while an item is in progress
// ----------------------------------------------------------------------------
module sonar_average_spike_filter_unit
    import sasf_pkg::*;
#(
    parameter int WINDOW         = WINDOW_DEF,
    parameter int STEPS_PER_TURN = STEPS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_in_item           i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_out_item          o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [THR_W-1:0]   threshold;
    logic [SCALE_W-1:0] scale;
    t_dp_cmd            cmd;
    t_dp_sts            sts;

    sasf_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .o_threshold (threshold),
        .o_scale     (scale)
    );

    sasf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    sasf_dp #(
        .WINDOW         (WINDOW),
        .STEPS_PER_TURN (STEPS_PER_TURN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .i_threshold (threshold),
        .i_scale     (scale),
        .o_out_data  (o_out_data)
    );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sonar average and spike filter. Echo and
// position beats go in under random sender gaps and receiver stalls, a
// scoreboard predicts the distance, average, spike and angle of every beat,
// and each output beat is compared field by field in order.
// ----------------------------------------------------------------------------
module tb;
    import sasf_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 60;
    localparam int SEG_ITEMS   = 272;

    class filter_scoreboard;
        logic [DIST_W-1:0]  dist_ring [WINDOW_DEF];
        int unsigned        next_slot;
        bit                 ring_wrapped;
        logic [28:0]        dist_sum;
        logic [THR_W-1:0]   thr_q8;
        logic [SCALE_W-1:0] scale_q16;
        t_out_item          pending_reports [$];
        int                 n_fail;

        function new();
            foreach (dist_ring[i]) dist_ring[i] = '0;
            next_slot    = 0;
            ring_wrapped = 1'b0;
            dist_sum     = '0;
            thr_q8       = THR_RST;
            scale_q16    = SCALE_RST;
            n_fail       = 0;
        endfunction

        function void write_reg(logic [REG_IDX_W-1:0] idx, logic [PDATA_W-1:0] value);
            case (idx)
                REG_THRESHOLD: thr_q8 = value[THR_W-1:0];
                REG_SCALE:     scale_q16 = value[SCALE_W-1:0];
                default: ;
            endcase
        endfunction

        function void predict_report(t_in_item beat);
            logic [35:0]       prod;
            logic [DIST_W-1:0] raw;
            logic [DIST_W-1:0] avg;
            logic [DIST_W-1:0] diff;
            int unsigned       cnt;
            int                r;
            t_out_item         e;
            prod = (36'(beat.echo_us) * 36'(scale_q16)) >> SCALE_SHIFT;
            raw  = (prod > 36'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
            dist_sum = dist_sum - 29'(dist_ring[next_slot]) + 29'(raw);
            dist_ring[next_slot] = raw;
            next_slot++;
            if (next_slot == WINDOW_DEF) begin
                next_slot    = 0;
                ring_wrapped = 1'b1;
            end
            cnt  = ring_wrapped ? WINDOW_DEF : next_slot;
            avg  = DIST_W'(32'(dist_sum) / cnt);
            diff = (raw > avg) ? raw - avg : avg - raw;
            e.spike      = (diff > thr_q8);
            e.raw_q8     = raw;
            e.average_q8 = avg;
            e.report_q8  = e.spike ? raw : avg;
            r = int'($signed(beat.step_position)) % STEPS_DEF;
            if (r < 0) r += STEPS_DEF;
            e.angle_deg = ANGLE_W'((r * DEG_PER_TURN) / STEPS_DEF);
            pending_reports.push_back(e);
        endfunction

        function void check_report(t_out_item got);
            t_out_item e;
            if (pending_reports.size() == 0) begin
                n_fail++;
                if (n_fail <= 10)
                    $display("unexpected output beat: angle=%0d report=%0d spike=%0b raw=%0d avg=%0d",
                             got.angle_deg, got.report_q8, got.spike, got.raw_q8, got.average_q8);
                return;
            end
            e = pending_reports.pop_front();
            if (got.angle_deg !== e.angle_deg || got.report_q8 !== e.report_q8 ||
                got.spike !== e.spike || got.raw_q8 !== e.raw_q8 ||
                got.average_q8 !== e.average_q8) begin
                n_fail++;
                if (n_fail <= 10) begin
                    $display("mismatch exp: angle=%0d report=%0d spike=%0b raw=%0d avg=%0d",
                             e.angle_deg, e.report_q8, e.spike, e.raw_q8, e.average_q8);
                    $display("         got: angle=%0d report=%0d spike=%0b raw=%0d avg=%0d",
                             got.angle_deg, got.report_q8, got.spike, got.raw_q8,
                             got.average_q8);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    t_in_item           in_data;
    logic               out_valid;
    logic               out_stall;
    t_out_item          out_data;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int               src_idle_pct;
    int               snk_idle_pct;
    int               quiet_cycles;
    filter_scoreboard sb = new();

    sonar_average_spike_filter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    always @(negedge clk) begin
        out_stall = ($urandom_range(99) < snk_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) sb.check_report(out_data);
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_echo(input logic [ECHO_W-1:0] echo, input logic [POS_W-1:0] pos);
        while ($urandom_range(99) < src_idle_pct) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid              = 1'b1;
        in_data.echo_us       = echo;
        in_data.step_position = pos;
        do @(posedge clk); while (in_stall);
        sb.predict_report(in_data);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (sb.pending_reports.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic apb_write(input logic [REG_IDX_W-1:0] idx, input logic [PDATA_W-1:0] value);
        psel    = 1'b1;
        pwrite  = 1'b1;
        penable = 1'b0;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_segment(input int n_items);
        int                  pick;
        int                  base;
        logic [ECHO_W-1:0]   echo;
        logic [POS_W-1:0]    pos;
        base = $urandom_range(0, 40000);
        pos  = POS_W'($urandom);
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(99);
            if (pick < 8) base = (pick < 2) ? int'($urandom & 32'hFFFFF) : $urandom_range(0, 40000);
            if (pick < 65) begin
                echo = ECHO_W'(base + $urandom_range(0, 400) - 200);
            end else if (pick < 85) begin
                echo = ECHO_W'($urandom);
            end else if (pick < 92) begin
                echo = pick[0] ? '0 : '1;
            end else begin
                echo = ECHO_W'(base) ^ (ECHO_W'(1) << $urandom_range(8, 19));
            end
            if ($urandom_range(3) == 0) begin
                pos = POS_W'($urandom);
            end else begin
                pos = pos + POS_W'($urandom_range(0, 64)) - POS_W'(32);
            end
            send_echo(echo, pos);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_stall    = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        quiet_cycles = 0;
        src_idle_pct = 10;
        snk_idle_pct = 56;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, field extremes and ring fill
        send_echo(20'd0, 16'sd0);
        send_echo(20'hFFFFF, 16'sd32767);
        send_echo(20'hFFFFF, -16'sd32768);
        send_echo(20'd1, -16'sd1);
        send_echo(20'd524288, 16'sd2048);
        send_echo(20'd0, -16'sd2049);

        // zero scale clears the whole ring
        wait_idle();
        apb_write(REG_SCALE, 32'd0);
        send_echo(20'd1000, 16'sd1);
        send_echo(20'hFFFFF, -16'sd2048);
        send_echo(20'd5, 16'sd2047);
        send_echo(20'd77, 16'sd1024);
        send_echo(20'd300, -16'sd1024);
        send_echo(20'd9, 16'sd5);
        send_echo(20'd12345, -16'sd5);
        send_echo(20'd2, 16'sd100);
        send_echo(20'd40000, 16'sd30000);
        send_echo(20'd1, -16'sd30000);

        // difference equal to threshold, then above it
        wait_idle();
        apb_write(REG_SCALE, 32'd256);
        apb_write(REG_THRESHOLD, 32'd900);
        send_echo(20'd1000, 16'sd512);
        send_echo(20'd2000, -16'sd512);

        // distance saturation
        wait_idle();
        apb_write(REG_SCALE, 32'd65535);
        apb_write(REG_THRESHOLD, 32'h1FF_FFFF);
        send_echo(20'hFFFFF, 16'sd3);
        send_echo(20'd4096, 16'sd0);

        for (int seg = 0; seg < 6; seg++) begin
            wait_idle();
            case (seg / 2)
                0: begin src_idle_pct = 10; snk_idle_pct = 56; end
                1: begin src_idle_pct = 56; snk_idle_pct = 10; end
                default: begin src_idle_pct = 0; snk_idle_pct = 0; end
            endcase
            case (seg)
                0: begin
                    apb_write(REG_THRESHOLD, 32'd0);
                    apb_write(REG_SCALE, 32'd65535);
                end
                1: begin
                    apb_write(REG_THRESHOLD, 32'h1FF_FFFF);
                    apb_write(REG_SCALE, 32'd0);
                end
                2: begin
                    apb_write(REG_THRESHOLD, $urandom_range(0, 65536));
                    apb_write(REG_SCALE, $urandom_range(0, 65535));
                end
                3: begin
                    apb_write(REG_THRESHOLD, 32'(THR_RST));
                    apb_write(REG_SCALE, 32'(SCALE_RST));
                end
                4: begin
                    apb_write(REG_THRESHOLD, $urandom);
                    apb_write(REG_SCALE, $urandom_range(0, 65535));
                end
                default: begin
                    apb_write(REG_THRESHOLD, $urandom_range(0, 4096));
                    apb_write(REG_SCALE, $urandom_range(1000, 9000));
                end
            endcase
            run_segment(SEG_ITEMS);
        end

        wait_idle();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (sb.n_fail == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

@@ sonar_average_spike_filter_unit.f @@
design/sasf_pkg.sv
design/sasf_regs.sv
design/sasf_div.sv
design/sasf_ctrl.sv
design/sasf_dp.sv
design/sonar_average_spike_filter_unit.sv
tb/tb.sv
